// ===== rtl/core/sscp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared types and constants of the stepper S-curve profiler core.
// ----------------------------------------------------------------------------
package sscp_pkg;

    localparam int TABLE_DEPTH_DEF  = 512;
    localparam int TABLE_AW         = $clog2(TABLE_DEPTH_DEF);
    localparam int PERIOD_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_START  = 2'd2,
        ACT_TARGET = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_MAX_POS   = 3'd0,
        CFG_DIVISOR   = 3'd1,
        CFG_START_LEN = 3'd2,
        CFG_STOP_LEN  = 3'd3,
        CFG_ACCEL     = 3'd4,
        CFG_DECEL     = 3'd5,
        CFG_MOVE      = 3'd6,
        CFG_SPEED     = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]  action;
        logic [8:0]  table_addr;
        logic [15:0] entry_pulses;
        logic [15:0] entry_period;
        logic        direction_cw;
        logic [31:0] reversal_point;
        logic [8:0]  speed_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] position_pulses;
        logic [31:0] position_units;
        logic [31:0] target_position;
        logic [15:0] period;
        logic [14:0] duty;
        logic        period_update;
        logic        move_done;
        logic        running;
        logic [31:0] elapsed_time;
    } t_out_item;

    // Handshake between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_LOOKUP,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/sscp_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sscp_divider
// Restoring 32 by 16 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sscp_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sscp_pkg::t_div_req i_req,
    output logic                   o_busy,
    output logic [31:0]            o_quotient
);
    import sscp_pkg::*;

    logic [31:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic [16:0] w_shift;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        w_shift = {r_rem[15:0], r_quo[31]};
        if (i_req.start) begin
            n_quo = i_req.dividend;
            n_rem = '0;
            n_den = (i_req.divisor == 16'd0) ? 16'd1 : i_req.divisor;
            n_cnt = 6'd32;
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_shift - {1'b0, r_den};
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy     = (r_cnt != 6'd0);
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/core/sscp_ramp_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sscp_ramp_table
// Ramp table memory: pulse count and period per entry, registered read.
// ----------------------------------------------------------------------------
module sscp_ramp_table #(
    parameter int PERIOD_WIDTH = sscp_pkg::PERIOD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [sscp_pkg::TABLE_AW-1:0] i_waddr,
    input  wire logic [15:0]                   i_wpulses,
    input  wire logic [PERIOD_WIDTH-1:0]       i_wperiod,
    input  wire logic [sscp_pkg::TABLE_AW-1:0] i_raddr,
    output logic [15:0]                        o_rpulses,
    output logic [PERIOD_WIDTH-1:0]            o_rperiod
);
    import sscp_pkg::*;

    logic [15+PERIOD_WIDTH:0] r_mem [TABLE_DEPTH_DEF];
    logic [15+PERIOD_WIDTH:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wpulses, i_wperiod};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rpulses = r_rd[15+PERIOD_WIDTH:PERIOD_WIDTH];
    assign o_rperiod = r_rd[PERIOD_WIDTH-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/stepper_s_curve_profiler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_s_curve_profiler_core
// S-curve ramp profiler for a stepper pulse generator.
// ----------------------------------------------------------------------------
// Usage: input transactions (tick, table write, start, target index) enter
// on i_in_valid / o_in_stall; every transaction gives exactly one result on
// o_out_valid / i_out_stall. Configuration is written via i_cfg_we with
// i_cfg_index and i_cfg_data while the core is idle.
// Sequence: the ramp entry of the current index (entry 0 for a start) is read
// as the transaction is accepted. A table write, a target update, a start or a
// tick while no move runs goes from the read state to the output state. An
// active tick launches the bit-serial divider that forms the position unit,
// waits while it runs, reads the period of the next ramp entry and loads the
// output register; in a speed hold it skips the period read.
// Flow: one transaction is in flight at a time, so the next one can be
// accepted in the cycle after the result is loaded. A stalled result holds
// the next result back, but not the acceptance of the transaction after it.
// Reset clears control and state registers; the ramp table contents are
// undefined until written. While the receiver stalls, the result is held.
// ----------------------------------------------------------------------------
module stepper_s_curve_profiler_core #(
    parameter int PERIOD_WIDTH = sscp_pkg::PERIOD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire sscp_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output sscp_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);
    import sscp_pkg::*;

    localparam int AW = TABLE_AW;

    // configuration
    logic [31:0] r_max_pos, r_accel, r_decel, r_move;
    logic [15:0] r_divisor;
    logic [8:0]  r_start_len, r_stop_len;
    logic        r_speed_mode;

    // state
    logic        r_active, r_count_up;
    logic [31:0] r_pulse_pos, r_target, r_units, r_done_cnt, r_at_speed, r_reversal;
    logic [31:0] r_time;
    logic [AW-1:0] r_index;
    logic [8:0]  r_hold;
    logic [PERIOD_WIDTH-1:0] r_period;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic        r_upd, r_mdone, r_busy_div;
    logic        r_out_valid;
    t_out_item   r_out;

    // memory
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rpulses;
    logic [PERIOD_WIDTH-1:0] w_rperiod;
    logic [AW-1:0] r_raddr;

    t_div_req    w_div_req;
    logic        w_div_busy;
    logic [31:0] w_quot;

    logic w_in_acc, w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_we = w_in_acc && (t_action'(i_in_data.action) == ACT_WRITE);

    sscp_ramp_table #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (i_in_data.table_addr[AW-1:0]),
        .i_wpulses (i_in_data.entry_pulses),
        .i_wperiod (PERIOD_WIDTH'(i_in_data.entry_period)),
        .i_raddr   (w_raddr),
        .o_rpulses (w_rpulses),
        .o_rperiod (w_rperiod)
    );

    sscp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_busy     (w_div_busy),
        .o_quotient (w_quot)
    );

    // Next pulse positions.
    logic [31:0] w_pp, w_tp;
    always_comb begin
        if (r_count_up) begin
            w_pp = (r_pulse_pos + 32'd1 >= r_max_pos) ? 32'd0 : r_pulse_pos + 32'd1;
            w_tp = (r_target + 32'd1 >= r_max_pos) ? 32'd0 : r_target + 32'd1;
        end else begin
            w_pp = (r_pulse_pos == 32'd0) ? r_max_pos - 32'd1 : r_pulse_pos - 32'd1;
            w_tp = (r_target == 32'd0) ? r_max_pos - 32'd1 : r_target - 32'd1;
        end
    end

    // Ramp step evaluated while the current entry's data is on the read port.
    logic [9:0]  w_total;
    logic [31:0] w_idx, w_ti, w_pd, w_pas;
    logic        w_hold, w_chg;
    always_comb begin
        w_total = {1'b0, r_start_len} + {1'b0, r_stop_len};
        w_ti    = {22'd0, w_total} - 32'd1;
        w_idx   = 32'(r_index);
        w_hold  = r_speed_mode && ((w_idx == {23'd0, r_hold}) ||
                  ({23'd0, r_hold} + w_idx == w_ti));
        w_pd    = r_done_cnt + 32'd1;
        w_pas   = (r_reversal == w_pd) ? {16'd0, w_rpulses} : r_at_speed + 32'd1;
        w_chg   = (w_pas >= {16'd0, w_rpulses});
        if (w_chg) begin
            if (w_pd <= r_accel && (w_idx + 32'd1 < {23'd0, r_start_len})) begin
                w_idx = w_idx + 32'd1;
                w_pas = '0;
            end
            if ((r_move - w_pd) <= r_decel && (r_speed_mode || w_pd >= (r_move >> 1))) begin
                if (w_idx + 32'd1 < {23'd0, r_start_len}) begin
                    w_idx = {22'd0, w_total} - w_idx;
                end
                w_idx = w_idx + 32'd1;
                w_pas = '0;
                if (w_idx >= {22'd0, w_total}) begin
                    w_idx = (w_total != 10'd0) ? w_ti : 32'd0;
                end
            end
        end
    end

    always_comb begin
        w_raddr = r_raddr;
        if (w_in_acc) begin
            w_raddr = (t_action'(i_in_data.action) == ACT_START) ? '0 : r_index;
        end else if (r_state == ST_DIV && r_busy_div && !w_div_busy && !w_hold) begin
            // The entry the step lands on is fetched as the step completes.
            w_raddr = w_idx[AW-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (t_action'(r_item.action) == ACT_TICK && r_active) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (r_busy_div && !w_div_busy) begin
                    n_state = (w_hold) ? ST_OUT : ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer toward the divider.
    always_comb begin
        w_div_req.start    = (r_state == ST_READ) && (n_state == ST_DIV);
        w_div_req.dividend = w_pp;
        w_div_req.divisor  = r_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max_pos    <= 32'hFFFF_FFFF;
            r_divisor    <= 16'd1;
            r_start_len  <= 9'd1;
            r_stop_len   <= 9'd1;
            r_accel      <= '0;
            r_decel      <= '0;
            r_move       <= '0;
            r_speed_mode <= 1'b0;
            r_active     <= 1'b0;
            r_count_up   <= 1'b1;
            r_pulse_pos  <= '0;
            r_target     <= '0;
            r_units      <= '0;
            r_done_cnt   <= '0;
            r_at_speed   <= '0;
            r_reversal   <= '0;
            r_time       <= '0;
            r_index      <= '0;
            r_hold       <= '0;
            r_period     <= '0;
            r_out_valid  <= 1'b0;
            r_busy_div   <= 1'b0;
            r_upd        <= 1'b0;
            r_mdone      <= 1'b0;
            r_raddr      <= '0;
        end else begin
            r_state <= n_state;
            r_raddr <= w_raddr;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MAX_POS:   r_max_pos    <= i_cfg_data;
                    CFG_DIVISOR:   r_divisor    <= i_cfg_data[15:0];
                    CFG_START_LEN: r_start_len  <= i_cfg_data[8:0];
                    CFG_STOP_LEN:  r_stop_len   <= i_cfg_data[8:0];
                    CFG_ACCEL:     r_accel      <= i_cfg_data;
                    CFG_DECEL:     r_decel      <= i_cfg_data;
                    CFG_MOVE:      r_move       <= i_cfg_data;
                    CFG_SPEED:     r_speed_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_upd   <= 1'b0;
                    r_mdone <= 1'b0;
                end
                ST_READ: begin
                    unique case (t_action'(r_item.action))
                        ACT_START: begin
                            r_active   <= 1'b1;
                            r_count_up <= r_item.direction_cw;
                            r_reversal <= r_item.reversal_point;
                            r_done_cnt <= '0;
                            r_at_speed <= '0;
                            r_index    <= '0;
                            r_time     <= '0;
                            r_period   <= w_rperiod;
                            r_upd      <= 1'b1;
                        end
                        ACT_TARGET: r_hold <= r_item.speed_index;
                        default: ;
                    endcase
                    r_busy_div <= 1'b0;
                end
                ST_DIV: begin
                    r_busy_div <= 1'b1;
                    if (r_busy_div && !w_div_busy) begin
                        r_pulse_pos <= w_pp;
                        r_target    <= w_tp;
                        r_units     <= w_quot;
                        if (!w_hold) begin
                            r_done_cnt <= w_pd;
                            r_at_speed <= w_pas;
                            r_index    <= w_idx[AW-1:0];
                            r_upd      <= w_chg;
                        end
                    end
                end
                ST_LOOKUP: begin
                    // Period of the new entry is now on the read port.
                    if (r_upd) begin
                        r_period <= w_rperiod;
                    end
                    if (r_done_cnt >= r_move && r_done_cnt > 32'd3) begin
                        r_active <= 1'b0;
                        r_index  <= '0;
                        r_mdone  <= 1'b1;
                    end else begin
                        r_time <= r_time + 32'(r_upd ? w_rperiod : r_period);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out.position_pulses <= r_pulse_pos;
            r_out.position_units  <= r_units;
            r_out.target_position <= r_target;
            r_out.period          <= 16'(r_period);
            r_out.duty            <= 15'(r_period >> 1);
            r_out.period_update   <= r_upd;
            r_out.move_done       <= r_mdone;
            r_out.running         <= r_active;
            r_out.elapsed_time    <= r_time;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input accepted while busy");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.move_done) |-> !o_out_data.running)
        else $error("move done while running");
    a_div_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> (t_action'(r_item.action) == ACT_TICK))
        else $error("divider started for non-tick");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");
`endif

endmodule
`default_nettype wire
